@@ design/dbd_pkg.sv @@
package dbd_pkg;

    // value widths inside the datapath
    localparam int VW = 46;         // q25 geometry values
    localparam int SCW = 19;        // sin and cos, q16
    localparam int ZW = 20;         // cordic angle accumulator, q16
    localparam int QB = 28;         // quotient magnitude bits before saturation
    localparam int QW = QB + 2;     // signed scaled value
    localparam int DIV_BITS = 7;
    localparam int DIV_STAGES = QB / DIV_BITS;
    localparam int SCALE_LAT = 3 + DIV_STAGES;
    localparam int IDXW = 3;

    localparam logic [IDXW-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [IDXW-1:0] REG_FRAME_W   = 3'd1;
    localparam logic [IDXW-1:0] REG_FRAME_H   = 3'd2;
    localparam logic [IDXW-1:0] REG_NET_W     = 3'd3;
    localparam logic [IDXW-1:0] REG_ROTATED   = 3'd4;

    localparam logic [15:0] RST_THRESHOLD = 16'd32768;
    localparam logic [13:0] RST_FRAME_W   = 14'd1920;
    localparam logic [13:0] RST_FRAME_H   = 14'd1080;
    localparam logic [13:0] RST_NET_W     = 14'd640;

    localparam logic [1:0] KIND_MAIN     = 2'd0;
    localparam logic [1:0] KIND_BBOX     = 2'd1;
    localparam logic [1:0] KIND_CORNER_A = 2'd2;
    localparam logic [1:0] KIND_CORNER_B = 2'd3;

    localparam logic signed [SCW-1:0] CORDIC_K    = 19'sd39797;
    localparam logic signed [ZW-1:0]  PI_Q16      = 20'sd205887;
    localparam logic signed [ZW-1:0]  HALF_PI_Q16 = 20'sd102944;

    localparam int Q24_MAX = 8388607;
    localparam int Q24_MIN = -8388608;

    typedef struct packed {
        logic [15:0] score_threshold;
        logic [13:0] frame_width;
        logic [13:0] frame_height;
        logic [13:0] net_width;
        logic        rotated_mode;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        last;
        logic [15:0] conf;
    } meta_t;

    typedef struct packed {
        meta_t              meta;
        logic [3:0][VW-1:0] val;
    } job_t;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [3:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            4'd0:  r = 20'sd51472;
            4'd1:  r = 20'sd30386;
            4'd2:  r = 20'sd16055;
            4'd3:  r = 20'sd8150;
            4'd4:  r = 20'sd4091;
            4'd5:  r = 20'sd2047;
            4'd6:  r = 20'sd1024;
            4'd7:  r = 20'sd512;
            4'd8:  r = 20'sd256;
            4'd9:  r = 20'sd128;
            4'd10: r = 20'sd64;
            4'd11: r = 20'sd32;
            4'd12: r = 20'sd16;
            4'd13: r = 20'sd8;
            4'd14: r = 20'sd4;
            default: r = 20'sd2;
        endcase
        return r;
    endfunction

endpackage

@@ design/detection_box_decoder_unit.sv @@
// channel   direction  transfer when              payload
// command   in         start & !busy             box_a..box_d, angle, score
// result    out        result_valid (one cycle)  kind, field_a..field_d, confidence, last
// config    in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// corner mode takes one detection per cycle while the fifo has room; in rotated mode the
// sin/cos unit (4 of its 16 iterations per cycle) and the four results leaving one per
// cycle set the pace, and a new detection is taken once the sin/cos unit passes on the last.
// reset returns the registers to their defaults and empties every stage.
// results cannot be held off; busy is high while the sin/cos unit iterates or the
// front stages back up.
module detection_box_decoder_unit #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [23:0]          box_a,
    input  logic signed [23:0]          box_b,
    input  logic signed [23:0]          box_c,
    input  logic signed [23:0]          box_d,
    input  logic signed [15:0]          angle,
    input  logic [15:0]                 score,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dbd_pkg::IDXW-1:0]    cfg_index,
    input  logic [15:0]                 cfg_data,
    output logic                        result_valid,
    output logic [1:0]                  kind,
    output logic signed [23:0]          field_a,
    output logic signed [23:0]          field_b,
    output logic signed [23:0]          field_c,
    output logic signed [23:0]          field_d,
    output logic [15:0]                 confidence,
    output logic                        last
);

    logic [15:0]    thr_reg;
    logic [13:0]    fw_reg;
    logic [13:0]    fh_reg;
    logic [13:0]    nw_reg;
    logic           rot_reg;
    dbd_pkg::cfg_t  cfg;
    logic           push;
    logic           full;
    logic           pop;
    logic           empty;
    dbd_pkg::job_t  push_job;
    dbd_pkg::job_t  pop_job;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg.score_threshold = thr_reg;
        cfg.frame_width = fw_reg;
        cfg.frame_height = fh_reg;
        // zero network width behaves as one
        cfg.net_width = (nw_reg == '0) ? 14'd1 : nw_reg;
        cfg.rotated_mode = rot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= dbd_pkg::RST_THRESHOLD;
            fw_reg <= dbd_pkg::RST_FRAME_W;
            fh_reg <= dbd_pkg::RST_FRAME_H;
            nw_reg <= dbd_pkg::RST_NET_W;
            rot_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dbd_pkg::REG_THRESHOLD: thr_reg <= cfg_data;
                dbd_pkg::REG_FRAME_W:   fw_reg <= cfg_data[13:0];
                dbd_pkg::REG_FRAME_H:   fh_reg <= cfg_data[13:0];
                dbd_pkg::REG_NET_W:     nw_reg <= cfg_data[13:0];
                dbd_pkg::REG_ROTATED:   rot_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    dbd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .start    (start),
        .busy     (busy),
        .box_a    (box_a),
        .box_b    (box_b),
        .box_c    (box_c),
        .box_d    (box_d),
        .angle    (angle),
        .score    (score),
        .push     (push),
        .push_job (push_job),
        .full     (full)
    );

    dbd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (empty)
    );

    dbd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .pop_job      (pop_job),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .kind         (kind),
        .field_a      (field_a),
        .field_b      (field_b),
        .field_c      (field_c),
        .field_d      (field_d),
        .confidence   (confidence),
        .last         (last)
    );

endmodule

@@ design/dbd_fifo.sv @@
module dbd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dbd_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output dbd_pkg::job_t  pop_job,
    output logic           empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    dbd_pkg::job_t  mem_reg [DEPTH];
    logic [PW-1:0]  wp_reg;
    logic [PW-1:0]  rp_reg;
    logic [CW-1:0]  cnt_reg;
    logic           do_push;
    logic           do_pop;

    assign full = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_push = push & ~full;
    assign do_pop = pop & ~empty;
    assign pop_job = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_pop)
            begin
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= push_job;
        end
    end

endmodule

@@ design/dbd_front.sv @@
module dbd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  dbd_pkg::cfg_t       cfg,
    input  logic                start,
    output logic                busy,
    input  logic signed [23:0]  box_a,
    input  logic signed [23:0]  box_b,
    input  logic signed [23:0]  box_c,
    input  logic signed [23:0]  box_d,
    input  logic signed [15:0]  angle,
    input  logic [15:0]         score,
    output logic                push,
    output dbd_pkg::job_t       push_job,
    input  logic                full
);

    localparam int VW = dbd_pkg::VW;
    localparam int SCW = dbd_pkg::SCW;
    localparam int ZW = dbd_pkg::ZW;
    localparam int PRW = 24 + SCW;

    typedef struct packed {
        logic signed [SCW-1:0] x;
        logic signed [SCW-1:0] y;
        logic signed [ZW-1:0]  z;
    } cstate_t;

    function automatic cstate_t cordic_step(input cstate_t s, input logic [3:0] i);
        cstate_t r;
        logic signed [SCW-1:0] xs;
        logic signed [SCW-1:0] ys;
        xs = $signed(s.x) >>> i;
        ys = $signed(s.y) >>> i;
        if (!s.z[ZW-1])
        begin
            r.x = $signed(s.x) - ys;
            r.y = $signed(s.y) + xs;
            r.z = $signed(s.z) - dbd_pkg::atan_q16(i);
        end
        else
        begin
            r.x = $signed(s.x) + ys;
            r.y = $signed(s.y) - xs;
            r.z = $signed(s.z) + dbd_pkg::atan_q16(i);
        end
        return r;
    endfunction

    function automatic logic signed [VW-1:0] min2(input logic signed [VW-1:0] p,
                                                  input logic signed [VW-1:0] q);
        return (q < p) ? q : p;
    endfunction

    function automatic logic signed [VW-1:0] max2(input logic signed [VW-1:0] p,
                                                  input logic signed [VW-1:0] q);
        return (q > p) ? q : p;
    endfunction

    // handshake chain
    logic take;
    logic keep;
    logic done1, load2, load3, load4, load5, done5, job_last;
    logic r2, r3, r4, r5;

    // stage 1: cordic
    logic                  v1_reg;
    logic [1:0]            cnt1_reg;
    cstate_t               cs1_reg;
    logic                  flip1_reg;
    logic                  rot1_reg;
    logic signed [23:0]    a1_reg, b1_reg, c1_reg, d1_reg;
    logic [15:0]           sc1_reg;
    logic signed [ZW-1:0]  z_in;
    logic signed [ZW-1:0]  z_red;
    logic                  flip_in;
    cstate_t               grp;

    // stage 2: sin and cos
    logic                  v2_reg;
    logic                  rot2_reg;
    logic signed [23:0]    a2_reg, b2_reg, c2_reg, d2_reg;
    logic [15:0]           sc2_reg;
    logic signed [SCW-1:0] sin2_reg, cos2_reg;

    // stage 3: products
    logic                  v3_reg;
    logic                  rot3_reg;
    logic signed [23:0]    a3_reg, b3_reg, c3_reg, d3_reg;
    logic [15:0]           sc3_reg;
    logic signed [PRW-1:0] hs3_reg, hc3_reg, ws3_reg, wc3_reg;

    // stage 4: box and corners
    logic                  v4_reg;
    logic                  rot4_reg;
    logic [15:0]           sc4_reg;
    logic signed [VW-1:0]  mb4_reg [4];
    logic signed [VW-1:0]  px4_reg [4];
    logic signed [VW-1:0]  py4_reg [4];
    logic signed [VW-1:0]  ca, cb, cc, cd, cx, cy, hs, hc, ws, wc;

    // stage 5: bounds and job issue
    logic                  v5_reg;
    logic                  rot5_reg;
    logic [1:0]            jcnt5_reg;
    logic [15:0]           sc5_reg;
    logic signed [VW-1:0]  mb5_reg [4];
    logic signed [VW-1:0]  px5_reg [4];
    logic signed [VW-1:0]  py5_reg [4];
    logic signed [VW-1:0]  mnx5_reg, mxx5_reg, mny5_reg, mxy5_reg;

    assign keep = (score >= cfg.score_threshold);

    assign push = v5_reg & ~full;
    assign job_last = ~rot5_reg | (jcnt5_reg == dbd_pkg::KIND_CORNER_B);
    assign done5 = push & job_last;
    assign r5 = ~v5_reg | done5;
    assign load5 = v4_reg & r5;
    assign r4 = ~v4_reg | load5;
    assign load4 = v3_reg & r4;
    assign r3 = ~v3_reg | load4;
    assign load3 = v2_reg & r3;
    assign r2 = ~v2_reg | load3;
    assign done1 = ~rot1_reg | (cnt1_reg == 2'd3);
    assign load2 = v1_reg & done1 & r2;
    assign busy = v1_reg & ~load2;
    assign take = start & ~busy & keep;

    // angle to q16, folded into the right half plane
    always_comb
    begin
        z_in = {angle[15], angle, 3'b000};
        z_red = z_in;
        flip_in = 1'b0;
        if (z_in > dbd_pkg::HALF_PI_Q16)
        begin
            z_red = z_in - dbd_pkg::PI_Q16;
            flip_in = 1'b1;
        end
        else if (z_in < -dbd_pkg::HALF_PI_Q16)
        begin
            z_red = z_in + dbd_pkg::PI_Q16;
            flip_in = 1'b1;
        end
    end

    // four cordic iterations per cycle
    always_comb
    begin
        grp = cs1_reg;
        for (int j = 0; j < 4; j++)
        begin
            grp = cordic_step(grp, {cnt1_reg, 2'(j)});
        end
    end

    always_comb
    begin
        ca = VW'(a3_reg);
        cb = VW'(b3_reg);
        cc = VW'(c3_reg);
        cd = VW'(d3_reg);
        cx = ca <<< 17;
        cy = cb <<< 17;
        hs = VW'(hs3_reg);
        hc = VW'(hc3_reg);
        ws = VW'(ws3_reg);
        wc = VW'(wc3_reg);
    end

    always_comb
    begin
        push_job.meta.kind = jcnt5_reg;
        push_job.meta.last = job_last;
        push_job.meta.conf = sc5_reg;
        case (jcnt5_reg)
            dbd_pkg::KIND_MAIN:
            begin
                push_job.val = {mb5_reg[3], mb5_reg[2], mb5_reg[1], mb5_reg[0]};
            end
            dbd_pkg::KIND_BBOX:
            begin
                push_job.val = {mxy5_reg - mny5_reg, mxx5_reg - mnx5_reg, mny5_reg, mnx5_reg};
            end
            dbd_pkg::KIND_CORNER_A:
            begin
                push_job.val = {py5_reg[1], px5_reg[1], py5_reg[2], px5_reg[2]};
            end
            default:
            begin
                push_job.val = {py5_reg[3], px5_reg[3], py5_reg[0], px5_reg[0]};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            cnt1_reg <= '0;
            jcnt5_reg <= dbd_pkg::KIND_MAIN;
        end
        else
        begin
            if (take)
            begin
                v1_reg <= 1'b1;
                cnt1_reg <= '0;
            end
            else
            begin
                if (load2)
                begin
                    v1_reg <= 1'b0;
                end
                if (v1_reg && rot1_reg && !done1)
                begin
                    cnt1_reg <= cnt1_reg + 1'b1;
                end
            end
            if (load2)
            begin
                v2_reg <= 1'b1;
            end
            else if (load3)
            begin
                v2_reg <= 1'b0;
            end
            if (load3)
            begin
                v3_reg <= 1'b1;
            end
            else if (load4)
            begin
                v3_reg <= 1'b0;
            end
            if (load4)
            begin
                v4_reg <= 1'b1;
            end
            else if (load5)
            begin
                v4_reg <= 1'b0;
            end
            if (load5)
            begin
                v5_reg <= 1'b1;
                jcnt5_reg <= dbd_pkg::KIND_MAIN;
            end
            else if (done5)
            begin
                v5_reg <= 1'b0;
            end
            else if (push)
            begin
                jcnt5_reg <= jcnt5_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cs1_reg.x <= dbd_pkg::CORDIC_K;
            cs1_reg.y <= '0;
            cs1_reg.z <= z_red;
            flip1_reg <= flip_in;
            rot1_reg <= cfg.rotated_mode;
            a1_reg <= box_a;
            b1_reg <= box_b;
            c1_reg <= box_c;
            d1_reg <= box_d;
            sc1_reg <= score;
        end
        else if (v1_reg && rot1_reg && !done1)
        begin
            cs1_reg <= grp;
        end

        if (load2)
        begin
            rot2_reg <= rot1_reg;
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
            c2_reg <= c1_reg;
            d2_reg <= d1_reg;
            sc2_reg <= sc1_reg;
            sin2_reg <= flip1_reg ? -$signed(grp.y) : $signed(grp.y);
            cos2_reg <= flip1_reg ? -$signed(grp.x) : $signed(grp.x);
        end

        if (load3)
        begin
            rot3_reg <= rot2_reg;
            a3_reg <= a2_reg;
            b3_reg <= b2_reg;
            c3_reg <= c2_reg;
            d3_reg <= d2_reg;
            sc3_reg <= sc2_reg;
            hs3_reg <= d2_reg * sin2_reg;
            hc3_reg <= d2_reg * cos2_reg;
            ws3_reg <= c2_reg * sin2_reg;
            wc3_reg <= c2_reg * cos2_reg;
        end

        if (load4)
        begin
            rot4_reg <= rot3_reg;
            sc4_reg <= sc3_reg;
            if (rot3_reg)
            begin
                // foot box: left and top from the foot point
                mb4_reg[0] <= cx - hs - (cc <<< 16);
                mb4_reg[1] <= cy + hc - (cd <<< 17);
                mb4_reg[2] <= cc <<< 17;
                mb4_reg[3] <= cd <<< 17;
            end
            else
            begin
                mb4_reg[0] <= cx;
                mb4_reg[1] <= cy;
                mb4_reg[2] <= (cc - ca) <<< 17;
                mb4_reg[3] <= (cd - cb) <<< 17;
            end
            px4_reg[0] <= cx - hs + wc;
            py4_reg[0] <= cy + hc + ws;
            px4_reg[1] <= cx + hs + wc;
            py4_reg[1] <= cy - hc + ws;
            px4_reg[2] <= cx + hs - wc;
            py4_reg[2] <= cy - hc - ws;
            px4_reg[3] <= cx - hs - wc;
            py4_reg[3] <= cy + hc - ws;
        end

        if (load5)
        begin
            rot5_reg <= rot4_reg;
            sc5_reg <= sc4_reg;
            mb5_reg <= mb4_reg;
            px5_reg <= px4_reg;
            py5_reg <= py4_reg;
            mnx5_reg <= min2(min2(px4_reg[0], px4_reg[1]), min2(px4_reg[2], px4_reg[3]));
            mxx5_reg <= max2(max2(px4_reg[0], px4_reg[1]), max2(px4_reg[2], px4_reg[3]));
            mny5_reg <= min2(min2(py4_reg[0], py4_reg[1]), min2(py4_reg[2], py4_reg[3]));
            mxy5_reg <= max2(max2(py4_reg[0], py4_reg[1]), max2(py4_reg[2], py4_reg[3]));
        end
    end

endmodule

@@ design/dbd_scale.sv @@
module dbd_scale (
    input  logic                            clk,
    input  logic [13:0]                     frame_width,
    input  logic [13:0]                     net_width,
    input  logic signed [dbd_pkg::VW-1:0]   value,
    output logic signed [dbd_pkg::QW-1:0]   scaled
);

    localparam int VW = dbd_pkg::VW;
    localparam int QB = dbd_pkg::QB;
    localparam int DB = dbd_pkg::DIV_BITS;
    localparam int NS = dbd_pkg::DIV_STAGES;
    localparam int LOW = 23;
    localparam int HW = VW - LOW;
    localparam int PRW = VW + 15;
    localparam int NW = PRW - 17;

    typedef struct packed {
        logic [13:0]   r;
        logic [DB-1:0] q;
    } dstep_t;

    // restoring division, a few quotient bits at a time
    function automatic dstep_t div_step(input logic [13:0] r_in, input logic [DB-1:0] bits,
                                        input logic [13:0] d);
        dstep_t      o;
        logic [14:0] t;
        logic [13:0] r;
        r = r_in;
        for (int j = DB - 1; j >= 0; j--)
        begin
            t = {r, bits[j]};
            if (t >= {1'b0, d})
            begin
                t = t - {1'b0, d};
                o.q[j] = 1'b1;
            end
            else
            begin
                o.q[j] = 1'b0;
            end
            r = t[13:0];
        end
        o.r = r;
        return o;
    endfunction

    logic [LOW+13:0]        lo_reg;
    logic signed [HW+14:0]  hi_reg;
    logic signed [PRW-1:0]  prod;
    logic signed [NW-1:0]   n_reg;
    logic [NW-1:0]          mag;
    logic                   mneg;
    logic [13:0]            dr_reg   [NS+1];
    logic [QB-1:0]          drest_reg[NS+1];
    logic [QB-1:0]          dq_reg   [NS+1];
    logic                   neg_reg  [NS+1];
    logic                   sat_reg  [NS+1];
    dstep_t                 st       [NS];
    logic [QB-1:0]          qs;

    // numerator plus half the denominator, floored by the fixed part of the divisor
    assign prod = (PRW'(hi_reg) <<< LOW) + PRW'($signed({1'b0, lo_reg}))
                + PRW'($signed({1'b0, net_width, 16'b0}));

    // negative numerators divide their complement, then complement back
    assign mneg = n_reg[NW-1];
    assign mag = mneg ? ~n_reg : n_reg;

    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            st[k] = div_step(dr_reg[k], drest_reg[k][QB-1:QB-DB], net_width);
        end
    end

    assign qs = sat_reg[NS] ? '1 : dq_reg[NS];
    assign scaled = neg_reg[NS] ? ~{2'b00, qs} : {2'b00, qs};

    always_ff @(posedge clk)
    begin
        lo_reg <= value[LOW-1:0] * frame_width;
        hi_reg <= $signed(value[VW-1:LOW]) * $signed({1'b0, frame_width});
        n_reg <= prod[PRW-1:17];
        neg_reg[0] <= mneg;
        sat_reg[0] <= (mag[NW-2:QB] >= {1'b0, net_width});
        dr_reg[0] <= mag[QB+13:QB];
        drest_reg[0] <= mag[QB-1:0];
        dq_reg[0] <= '0;
        for (int k = 0; k < NS; k++)
        begin
            neg_reg[k+1] <= neg_reg[k];
            sat_reg[k+1] <= sat_reg[k];
            dr_reg[k+1] <= st[k].r;
            drest_reg[k+1] <= {drest_reg[k][QB-DB-1:0], {DB{1'b0}}};
            dq_reg[k+1] <= {dq_reg[k][QB-DB-1:0], st[k].q};
        end
    end

endmodule

@@ design/dbd_back.sv @@
module dbd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  dbd_pkg::cfg_t       cfg,
    input  dbd_pkg::job_t       pop_job,
    input  logic                empty,
    output logic                pop,
    output logic                result_valid,
    output logic [1:0]          kind,
    output logic signed [23:0]  field_a,
    output logic signed [23:0]  field_b,
    output logic signed [23:0]  field_c,
    output logic signed [23:0]  field_d,
    output logic [15:0]         confidence,
    output logic                last
);

    localparam int QW = dbd_pkg::QW;
    localparam int LAT = dbd_pkg::SCALE_LAT;

    function automatic logic signed [23:0] sat24(input logic signed [QW:0] v);
        logic signed [23:0] r;
        if (v > (QW+1)'(dbd_pkg::Q24_MAX))
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < (QW+1)'(dbd_pkg::Q24_MIN))
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

    logic signed [QW-1:0]  lane_q [4];
    logic                  mv_reg [LAT];
    dbd_pkg::meta_t        mm_reg [LAT];
    logic                  pv_reg;
    dbd_pkg::meta_t        pm_reg;
    logic signed [QW:0]    pval_reg [4];
    logic signed [QW:0]    lq [4];
    logic signed [QW:0]    lc, tc, fw256, fh256, sx, sy;
    logic                  is_rect;

    assign pop = ~empty;

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        dbd_scale u_lane (
            .clk         (clk),
            .frame_width (cfg.frame_width),
            .net_width   (cfg.net_width),
            .value       (pop_job.val[k]),
            .scaled      (lane_q[k])
        );
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            lq[k] = (QW+1)'(lane_q[k]);
        end
        is_rect = (mm_reg[LAT-1].kind == dbd_pkg::KIND_MAIN)
               || (mm_reg[LAT-1].kind == dbd_pkg::KIND_BBOX);
        fw256 = (QW+1)'($signed({1'b0, cfg.frame_width, 8'b0}));
        fh256 = (QW+1)'($signed({1'b0, cfg.frame_height, 8'b0}));
        lc = lq[0][QW] ? '0 : lq[0];
        tc = lq[1][QW] ? '0 : lq[1];
        sx = lc + lq[2];
        sy = tc + lq[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                mv_reg[k] <= 1'b0;
            end
            pv_reg <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            mv_reg[0] <= pop;
            for (int k = 1; k < LAT; k++)
            begin
                mv_reg[k] <= mv_reg[k-1];
            end
            pv_reg <= mv_reg[LAT-1];
            result_valid <= pv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mm_reg[0] <= pop_job.meta;
        for (int k = 1; k < LAT; k++)
        begin
            mm_reg[k] <= mm_reg[k-1];
        end
        pm_reg <= mm_reg[LAT-1];
        if (is_rect)
        begin
            // clamp left and top at zero, trim width and height at the frame edges
            pval_reg[0] <= lc;
            pval_reg[1] <= tc;
            pval_reg[2] <= (sx > fw256) ? fw256 - lc : lq[2];
            pval_reg[3] <= (sy > fh256) ? fh256 - tc : lq[3];
        end
        else
        begin
            pval_reg <= lq;
        end
        kind <= pm_reg.kind;
        last <= pm_reg.last;
        confidence <= pm_reg.conf;
        field_a <= sat24(pval_reg[0]);
        field_b <= sat24(pval_reg[1]);
        field_c <= sat24(pval_reg[2]);
        field_d <= sat24(pval_reg[3]);
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam logic [dbd_pkg::IDXW-1:0] REG_SPARE = 3'd7;   // no register behind this index
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [1:0]  kind;
        logic [23:0] fa, fb, fc, fd;
        logic [15:0] conf;
        logic        last;
    } box_result_t;

    class box_scoreboard;
        longint thr, fw, fh, nw;
        bit rotated;
        box_result_t expected_boxes[$];
        int errors;
        int kept, dropped, checked;
        longint atan_tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                 256, 128, 64, 32, 16, 8, 4, 2};

        function new();
            thr = 32768; fw = 1920; fh = 1080; nw = 640; rotated = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void write_reg(logic [dbd_pkg::IDXW-1:0] idx, logic [15:0] data);
            case (idx)
                dbd_pkg::REG_THRESHOLD: thr = data;
                dbd_pkg::REG_FRAME_W:   fw = data[13:0];
                dbd_pkg::REG_FRAME_H:   fh = data[13:0];
                dbd_pkg::REG_NET_W:     nw = data[13:0];
                dbd_pkg::REG_ROTATED:   rotated = data[0];
                default: ;
            endcase
        endfunction

        function longint floor_div(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && n < 0)
                q--;
            return q;
        endfunction

        function longint to_pixels(longint v);
            longint n;
            n = (nw == 0) ? 1 : nw;
            return floor_div(v * fw + n * 65536, n * 131072);
        endfunction

        function logic [23:0] sat(longint v);
            if (v < dbd_pkg::Q24_MIN)
                return 24'h800000;
            if (v > dbd_pkg::Q24_MAX)
                return 24'h7fffff;
            return v[23:0];
        endfunction

        function void sin_cos(longint ang, output longint s, output longint c);
            longint z, x, y, xn;
            bit flip;
            z = ang * 8; x = 39797; y = 0; flip = 0;
            if (z > 102944) begin
                z -= 205887; flip = 1;
            end
            else if (z < -102944) begin
                z += 205887; flip = 1;
            end
            for (int i = 0; i < 16; i++) begin
                if (z >= 0) begin
                    xn = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
                end
                else begin
                    xn = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
                end
                x = xn;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function void add_result(logic [1:0] k, longint a, longint b, longint c, longint d,
                                 logic [15:0] conf, logic last);
            box_result_t r;
            r.kind = k; r.fa = sat(a); r.fb = sat(b); r.fc = sat(c); r.fd = sat(d);
            r.conf = conf; r.last = last;
            expected_boxes.insert(expected_boxes.size(), r);
        endfunction

        function void add_rect(logic [1:0] k, longint l, longint t, longint w, longint h,
                               logic [15:0] conf, logic last);
            longint pl, pt, pw, ph;
            pl = to_pixels(l); pt = to_pixels(t); pw = to_pixels(w); ph = to_pixels(h);
            if (pl < 0) pl = 0;
            if (pt < 0) pt = 0;
            if (pl + pw > fw * 256) pw -= pl + pw - fw * 256;
            if (pt + ph > fh * 256) ph -= pt + ph - fh * 256;
            add_result(k, pl, pt, pw, ph, conf, last);
        endfunction

        function void note_detection(longint a, longint b, longint c, longint d,
                                     longint ang, logic [15:0] sc);
            longint u, s, co, cx, cy, hs, hc, ws, wc, mnx, mxx, mny, mxy;
            longint px[4], py[4];
            u = 131072;
            if (sc < thr) begin
                dropped++;
                return;
            end
            kept++;
            if (!rotated) begin
                add_rect(dbd_pkg::KIND_MAIN, a * u, b * u, (c - a) * u, (d - b) * u, sc, 1);
                return;
            end
            sin_cos(ang, s, co);
            cx = a * u; cy = b * u;
            hs = d * s; hc = d * co; ws = c * s; wc = c * co;
            add_rect(dbd_pkg::KIND_MAIN, cx - hs - c * 65536, cy + hc - d * u, c * u, d * u,
                     sc, 0);
            px[0] = cx - hs + wc; py[0] = cy + hc + ws;
            px[1] = cx + hs + wc; py[1] = cy - hc + ws;
            px[2] = 2 * cx - px[0]; py[2] = 2 * cy - py[0];
            px[3] = 2 * cx - px[1]; py[3] = 2 * cy - py[1];
            mnx = px[0]; mxx = px[0]; mny = py[0]; mxy = py[0];
            for (int k = 1; k < 4; k++) begin
                if (px[k] < mnx) mnx = px[k];
                if (px[k] > mxx) mxx = px[k];
                if (py[k] < mny) mny = py[k];
                if (py[k] > mxy) mxy = py[k];
            end
            add_rect(dbd_pkg::KIND_BBOX, mnx, mny, mxx - mnx, mxy - mny, sc, 0);
            add_result(dbd_pkg::KIND_CORNER_A, to_pixels(px[2]), to_pixels(py[2]),
                       to_pixels(px[1]), to_pixels(py[1]), sc, 0);
            add_result(dbd_pkg::KIND_CORNER_B, to_pixels(px[0]), to_pixels(py[0]),
                       to_pixels(px[3]), to_pixels(py[3]), sc, 1);
        endfunction

        task check_box(box_result_t got);
            box_result_t w;
            if (expected_boxes.size() == 0) begin
                report($sformatf("unexpected result kind %0d", got.kind));
                return;
            end
            w = expected_boxes.pop_front();
            checked++;
            if (got.kind !== w.kind || got.fa !== w.fa || got.fb !== w.fb ||
                got.fc !== w.fc || got.fd !== w.fd || got.conf !== w.conf ||
                got.last !== w.last)
                report($sformatf("got k%0d %h %h %h %h c%h l%b, want k%0d %h %h %h %h c%h l%b",
                       got.kind, got.fa, got.fb, got.fc, got.fd, got.conf, got.last,
                       w.kind, w.fa, w.fb, w.fc, w.fd, w.conf, w.last));
        endtask

        function int pending();
            return expected_boxes.size();
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic signed [23:0] box_a = '0, box_b = '0, box_c = '0, box_d = '0;
    logic signed [15:0] angle = '0;
    logic [15:0] score = '0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [dbd_pkg::IDXW-1:0] cfg_index = dbd_pkg::REG_THRESHOLD;
    logic [15:0] cfg_data = '0;
    logic result_valid;
    logic [1:0] kind;
    logic signed [23:0] field_a, field_b, field_c, field_d;
    logic [15:0] confidence;
    logic last;

    box_scoreboard sb = new();
    int cycles = 0;

    detection_box_decoder_unit u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .box_a(box_a), .box_b(box_b), .box_c(box_c), .box_d(box_d),
        .angle(angle), .score(score),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .result_valid(result_valid), .kind(kind), .field_a(field_a), .field_b(field_b),
        .field_c(field_c), .field_d(field_d), .confidence(confidence), .last(last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // pre-edge values are seen here, so every transfer is taken as the block saw it
    always @(posedge clk)
    begin
        box_result_t r;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        else if (rst_n) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (start && !busy)
                sb.note_detection(box_a, box_b, box_c, box_d, angle, score);
            if (result_valid) begin
                r.kind = kind; r.fa = field_a; r.fb = field_b; r.fc = field_c;
                r.fd = field_d; r.conf = confidence; r.last = last;
                sb.check_box(r);
            end
        end
    end

    // leaves valid high; the caller drops it once the writes are done
    task automatic write_reg(logic [dbd_pkg::IDXW-1:0] idx, logic [15:0] data);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic wait_idle();
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(int thr, int fw, int fh, int nw, int rot);
        wait_idle();
        write_reg(dbd_pkg::REG_THRESHOLD, 16'(thr));
        write_reg(dbd_pkg::REG_FRAME_W, 16'(fw));
        write_reg(dbd_pkg::REG_FRAME_H, 16'(fh));
        write_reg(dbd_pkg::REG_NET_W, 16'(nw));
        write_reg(dbd_pkg::REG_ROTATED, 16'(rot));
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic send_detection(logic [23:0] a, logic [23:0] b, logic [23:0] c,
                                  logic [23:0] d, logic [15:0] ang, logic [15:0] sc);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        box_a <= a; box_b <= b; box_c <= c; box_d <= d; angle <= ang; score <= sc;
        do @(posedge clk); while (busy);
    endtask

    function automatic logic [23:0] pick_coord();
        case ($urandom_range(0, 4))
            0: return 24'($urandom());
            1: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
            2: return 24'(-$urandom_range(0, 8000));
            default: return 24'($urandom_range(0, 700 * 256));
        endcase
    endfunction

    function automatic logic [15:0] pick_score();
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom());
        return 16'($urandom_range(sb.thr > 65535 ? 65535 : sb.thr, 65535));
    endfunction

    task automatic random_burst(int n);
        for (int i = 0; i < n; i++) begin
            send_detection(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                           16'($urandom()), pick_score());
            // hold off once so the pipeline fully empties mid-phase
            if (i == n / 2) begin
                start <= 0;
                @(posedge clk);
                while (sb.pending() > 0)
                    @(posedge clk);
            end
        end
        start <= 0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // corner mode at reset defaults: field extremes and the threshold edge
        send_detection(24'h000000, 24'h000000, 24'h7fffff, 24'h7fffff, 16'h0, 16'hffff);
        send_detection(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 16'h7fff, 16'h8000);
        send_detection(24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000, 16'h8000, 16'h7fff);
        send_detection(24'h000100, 24'h000200, 24'h0a0000, 24'h080000, 16'h1234, 16'h0000);
        send_detection(24'h020000, 24'h010000, 24'h0f0000, 24'h0c0000, 16'h0, 16'hc000);
        send_detection(24'h000080, 24'h000080, 24'h000180, 24'h000180, 16'h0, 16'h8001);
        start <= 0;
        // rotated: zero, quarter turns, a half turn and the angle extremes
        configure(32768, 1920, 1080, 640, 1);
        send_detection(24'h014000, 24'h00c800, 24'h003200, 24'h006400, 16'd0, 16'hffff);
        send_detection(24'h014000, 24'h00c800, 24'h003200, 24'h006400, 16'd12868, 16'h9000);
        send_detection(24'h014000, 24'h00c800, 24'h003200, 24'h006400, -16'sd12868, 16'h9000);
        send_detection(24'h014000, 24'h00c800, 24'h003200, 24'h006400, 16'd12869, 16'h9000);
        send_detection(24'h014000, 24'h00c800, 24'h003200, 24'h006400, 16'd25736, 16'h9000);
        send_detection(24'h000000, 24'h000000, 24'h7fffff, 24'h7fffff, 16'h7fff, 16'hffff);
        send_detection(24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff, 16'h8000, 16'hffff);
        send_detection(24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 16'd3000, 16'h8000);
        send_detection(24'h014000, 24'h00c800, 24'h003200, 24'h006400, 16'd5000, 16'h7fff);
        start <= 0;
        // zero sizes: net width falls back to one, edges sit at zero
        configure(0, 0, 0, 0, 1);
        write_reg(REG_SPARE, 16'hffff);
        cfg_valid <= 0;
        @(posedge clk);
        send_detection(24'h000400, 24'h000300, 24'h000200, 24'h000100, 16'd4000, 16'h0000);
        send_detection(24'hfff000, 24'h001000, 24'h000800, 24'h000800, 16'd0, 16'h0001);
        start <= 0;

        configure(32768, 1920, 1080, 640, 0);
        random_burst(25);
        configure(6554, 1920, 1080, 640, 1);
        random_burst(25);
        configure(65535, 16383, 16383, 1, 1);
        random_burst(20);
        configure(6554, 1, 1, 16383, 0);
        random_burst(25);
        configure(6554, 16383, 16383, 16383, 1);
        random_burst(20);
        configure($urandom_range(6554, 40000), $urandom_range(1, 16383),
                  $urandom_range(1, 16383), $urandom_range(1, 16383), 1);
        random_burst(20);
        configure($urandom_range(6554, 40000), $urandom_range(1, 4000),
                  $urandom_range(1, 4000), $urandom_range(1, 4000), 0);
        random_burst(15);

        wait_idle();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        $display("covered %0d kept and %0d dropped detections, %0d results checked",
                 sb.kept, sb.dropped, sb.checked);
        $display("corner and rotated modes over extreme, zero and random frame settings");
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
design/dbd_pkg.sv
design/dbd_fifo.sv
design/dbd_front.sv
design/dbd_scale.sv
design/dbd_back.sv
design/detection_box_decoder_unit.sv
bench/tb_top.sv
